// ===== design/arpc_pkg.sv =====
// Package with constants, status codes and state types for the ARP cache.
package arpc_pkg;

   localparam int TableEntries = 64;
   localparam int IdxW = $clog2(TableEntries);

   localparam logic [15:0] HwEthernet = 16'h0001;
   localparam logic [15:0] ProtIpv4 = 16'h0800;
   localparam logic [15:0] OpRequest = 16'h0001;
   localparam logic [15:0] OpReply = 16'h0002;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_NOT_SUPPORTED = 3'd1,
      ST_NO_ENTRY = 3'd2,
      ST_INVALID = 3'd3,
      ST_TABLE_FULL = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_DECIDE,
      S_TSEARCH,
      S_TREAD,
      S_TDECIDE,
      S_OUT
   } state_type;

endpackage

// ===== design/arpc_ram.sv =====
// Simple dual-port RAM with registered read data.
module arpc_ram #(
   parameter int Depth = 64,
   parameter int Width = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/arp_cache_and_responder.sv =====
// ARP cache and responder top level: table search, update and result register.
// An item walks the IP memory one entry a cycle (N = TableEntries): a lookup or a
// reply walks it once, a request twice (sender, then target), a refused packet not at all.
// One item at a time: the block returns to idle as the result is loaded and takes the next
// one only then; a result not yet taken holds the block in output state.
// Reset clears the valid and active flag registers at once; no clearing pass.
module arp_cache_and_responder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata from bit 0: hw_type, protocol, operation, sender_mac, sender_ip,
   // target_ip, lookup_ip.
   input  logic [191:0] req_tdata,
   // tuser: func.
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata from bit 0: status, found, found_mac, reply_valid, reply_dst_mac,
   // reply_dst_ip, reply_src_mac, reply_src_ip, request_valid, request_ip,
   // zero pad to 248 bits.
   output logic [247:0] rsp_tdata
);

   localparam int N = arpc_pkg::TableEntries;
   localparam int W = arpc_pkg::IdxW;

   arpc_pkg::state_type state_ff, state_in;

   logic         func_ff;
   logic [15:0]  hw_ff, prot_ff, op_ff;
   logic [47:0]  smac_ff;
   logic [31:0]  sip_ff, tip_ff, lip_ff;

   logic [N-1:0] valid_ff, valid_in, active_ff, active_in;
   logic [W:0]   cnt_ff, cnt_in;
   logic         hit_ff, hit_in;
   logic [W-1:0] hidx_ff, hidx_in;
   logic         rsp_valid_ff;
   logic [247:0] rsp_data_ff;
   logic [247:0] res_ff, res_in;
   logic         out_free;

   // Memory ports.
   logic         ip_we, mac_we;
   logic [W-1:0] ip_wa, mac_wa, ip_ra, mac_ra;
   logic [31:0]  ip_wd, ip_rd;
   logic [47:0]  mac_wd, mac_rd;
   logic [W-1:0] cnt_idx, rd_idx_ff;
   logic         rd_live_ff;

   arpc_ram #(.Depth(N), .Width(32)) u_ip_ram (
      .clock(clock), .wr_en(ip_we), .wr_addr(ip_wa), .wr_data(ip_wd),
      .rd_addr(ip_ra), .rd_data(ip_rd)
   );
   arpc_ram #(.Depth(N), .Width(48)) u_mac_ram (
      .clock(clock), .wr_en(mac_we), .wr_addr(mac_wa), .wr_data(mac_wd),
      .rd_addr(mac_ra), .rd_data(mac_rd)
   );

   assign req_tready = (state_ff == arpc_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign cnt_idx = cnt_ff[W-1:0];
   // The output register can take a new result when it is empty or being read.
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Free slot: lowest invalid index, priority encoder over the flags.
   logic         free_ok;
   logic [W-1:0] free_idx;
   always_comb begin
      free_ok = 1'b0;
      free_idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_ok = 1'b1;
            free_idx = W'(i);
         end
      end
   end

   logic [31:0] key;
   logic        supported, is_req;
   assign supported = (hw_ff == arpc_pkg::HwEthernet) && (prot_ff == arpc_pkg::ProtIpv4);
   assign is_req = (op_ff == arpc_pkg::OpRequest);
   assign key = (state_ff == arpc_pkg::S_TSEARCH) ? tip_ff : (func_ff ? lip_ff : sip_ff);

   // Input capture and flags.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         func_ff <= req_tuser;
         hw_ff <= req_tdata[15:0];
         prot_ff <= req_tdata[31:16];
         op_ff <= req_tdata[47:32];
         smac_ff <= req_tdata[95:48];
         sip_ff <= req_tdata[127:96];
         tip_ff <= req_tdata[159:128];
         lip_ff <= req_tdata[191:160];
      end
      rd_idx_ff <= ip_ra;
      res_ff <= res_in;
      hidx_ff <= hidx_in;
      // The finished result moves to the output register once that is free.
      if (state_ff == arpc_pkg::S_OUT && out_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arpc_pkg::S_IDLE;
         valid_ff <= '0;
         active_ff <= '0;
         cnt_ff <= '0;
         hit_ff <= 1'b0;
         rd_live_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         active_ff <= active_in;
         cnt_ff <= cnt_in;
         hit_ff <= hit_in;
         rd_live_ff <= (state_ff == arpc_pkg::S_SEARCH || state_ff == arpc_pkg::S_TSEARCH)
                       && !cnt_ff[W];
         if (state_ff == arpc_pkg::S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         arpc_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = arpc_pkg::S_SEARCH;
            end
         end
         arpc_pkg::S_SEARCH: begin
            if (!func_ff && (!supported || (!is_req && op_ff != arpc_pkg::OpReply))) begin
               state_in = arpc_pkg::S_OUT;
            end else if (cnt_ff[W] && !rd_live_ff) begin
               state_in = arpc_pkg::S_DECIDE;
            end
         end
         arpc_pkg::S_DECIDE: begin
            state_in = (!func_ff && is_req) ? arpc_pkg::S_TSEARCH : arpc_pkg::S_TREAD;
         end
         arpc_pkg::S_TSEARCH: begin
            if (cnt_ff[W] && !rd_live_ff) begin
               state_in = arpc_pkg::S_TREAD;
            end
         end
         arpc_pkg::S_TREAD: state_in = arpc_pkg::S_TDECIDE;
         arpc_pkg::S_TDECIDE: state_in = arpc_pkg::S_OUT;
         arpc_pkg::S_OUT: begin
            if (out_free) begin
               state_in = arpc_pkg::S_IDLE;
            end
         end
         default: state_in = arpc_pkg::S_IDLE;
      endcase
   end

   // Datapath and table updates.
   always_comb begin
      valid_in = valid_ff;
      active_in = active_ff;
      cnt_in = cnt_ff;
      hit_in = hit_ff;
      hidx_in = hidx_ff;
      res_in = res_ff;
      ip_we = 1'b0;
      mac_we = 1'b0;
      ip_wa = free_idx;
      ip_wd = key;
      mac_wa = hidx_ff;
      mac_wd = smac_ff;
      ip_ra = cnt_idx;
      mac_ra = hidx_ff;
      unique case (state_ff)
         arpc_pkg::S_IDLE: begin
            cnt_in = '0;
            hit_in = 1'b0;
         end
         arpc_pkg::S_SEARCH, arpc_pkg::S_TSEARCH: begin
            if (!cnt_ff[W]) begin
               cnt_in = cnt_ff + 1'b1;
            end
            // Compare the entry read in the previous cycle; keep the first hit.
            if (rd_live_ff && !hit_ff && valid_ff[rd_idx_ff] && ip_rd == key) begin
               hit_in = 1'b1;
               hidx_in = rd_idx_ff;
            end
         end
         arpc_pkg::S_DECIDE: begin
            cnt_in = '0;
            if (func_ff) begin
               if (!hit_ff && free_ok) begin
                  valid_in[free_idx] = 1'b1;
                  active_in[free_idx] = 1'b0;
                  ip_we = 1'b1;
               end
            end else if (hit_ff) begin
               if (!active_ff[hidx_ff]) begin
                  active_in[hidx_ff] = 1'b1;
                  mac_we = 1'b1;
               end
            end else if (free_ok) begin
               valid_in[free_idx] = 1'b1;
               active_in[free_idx] = 1'b1;
               ip_we = 1'b1;
               mac_we = 1'b1;
               mac_wa = free_idx;
            end
            // The target search restarts its hit tracking.
            if (!func_ff && is_req) begin
               hit_in = 1'b0;
            end
         end
         default: ;
      endcase
      // Build the result once the table answer is known.
      if (state_ff == arpc_pkg::S_SEARCH &&
          !func_ff && (!supported || (!is_req && op_ff != arpc_pkg::OpReply))) begin
         res_in = '0;
         res_in[2:0] = supported ? arpc_pkg::ST_INVALID : arpc_pkg::ST_NOT_SUPPORTED;
      end else if (state_ff == arpc_pkg::S_DECIDE) begin
         res_in = '0;
         if (func_ff) begin
            if (!hit_ff) begin
               res_in[2:0] = free_ok ? arpc_pkg::ST_NO_ENTRY : arpc_pkg::ST_TABLE_FULL;
               res_in[213] = free_ok;
               res_in[245:214] = free_ok ? lip_ff : 32'd0;
            end
         end else if (!is_req) begin
            res_in[2:0] = (hit_ff || free_ok) ? arpc_pkg::ST_OK : arpc_pkg::ST_TABLE_FULL;
         end
      end else if (state_ff == arpc_pkg::S_TDECIDE) begin
         if (func_ff) begin
            if (hit_ff) begin
               if (active_ff[hidx_ff]) begin
                  res_in[2:0] = arpc_pkg::ST_OK;
                  res_in[3] = 1'b1;
                  res_in[51:4] = mac_rd;
               end else begin
                  res_in[2:0] = arpc_pkg::ST_NO_ENTRY;
               end
            end
         end else if (is_req) begin
            res_in = '0;
            if (hit_ff && active_ff[hidx_ff]) begin
               res_in[2:0] = arpc_pkg::ST_OK;
               res_in[52] = 1'b1;
               res_in[100:53] = smac_ff;
               res_in[132:101] = sip_ff;
               res_in[180:133] = mac_rd;
               res_in[212:181] = tip_ff;
            end else begin
               res_in[2:0] = arpc_pkg::ST_NO_ENTRY;
            end
         end
      end
   end

   // A result is presented only from the output state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == arpc_pkg::S_OUT)
      else $error("result raised outside output state");
   // The block takes no item while busy.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != arpc_pkg::S_IDLE) |-> !req_tready)
      else $error("ready while busy");
   // An active entry is always valid.
   assert property (@(posedge clock) disable iff (reset)
      (active_ff & ~valid_ff) == '0)
      else $error("active entry without valid");

endmodule
